>>> src/spo2_window_estimator_assert.svh
// Assertion macros for the spo2 window estimator RTL
`ifndef SPO2_WINDOW_ESTIMATOR_ASSERT_SVH
`define SPO2_WINDOW_ESTIMATOR_ASSERT_SVH

// Clocked check, disabled while reset is asserted
`define SWE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset
`define SWE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/swe_pkg.sv
// Shared constants, types and command codes for the spo2 window estimator
package swe_pkg;

  localparam int WINDOW      = 32;  // power of two, 2..256
  localparam int SAMPLE_BITS = 18;

  localparam int IN_W   = 18;
  localparam int OUT_W  = 18;
  localparam int SPO2_W = 7;
  localparam int AW     = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + AW;
  localparam int COEF_W = 23;
  localparam int MUL_W  = (SUM_W > COEF_W) ? SUM_W : COEF_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int NUM_W  = SAMPLE_BITS + SUM_W;
  localparam int QW     = 20;                 // Q4.16 ratio
  localparam int DSH_W  = NUM_W + QW - 1;
  localparam int T_W    = 2 * QW + 2;         // coef A (22 bits) times r
  localparam int HALF_T = T_W / 2;
  localparam int V_W    = 64;
  localparam int CNT_W  = (FILL_W > $clog2(QW)) ? FILL_W : $clog2(QW);

  localparam logic [COEF_W-1:0] COEF_A = COEF_W'(2953052);
  localparam logic [COEF_W-1:0] COEF_B = COEF_W'(1989280);
  localparam logic [COEF_W-1:0] COEF_C = COEF_W'(6215762);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_SCAN,
    OP_SWING,
    OP_MUL_NUM,
    OP_MUL_DEN,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_T,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_MUL_B,
    OP_POLY,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e           op;
    logic          rd;
    logic          acc;
    logic [AW-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic fill_next;  // the pending write completes the window
  } status_t;

  typedef struct packed {
    logic [SPO2_W-1:0] spo2_percent;
    logic              window_ready;
    logic [OUT_W-1:0]  ir_mean;
    logic [OUT_W-1:0]  red_mean;
    logic [OUT_W-1:0]  ir_swing;
    logic [OUT_W-1:0]  red_swing;
  } res_t;

endpackage

>>> src/swe_if.sv
// Valid/ready channel interfaces for sample pairs and results
interface swe_in_if import swe_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] ir_sample;
  logic [IN_W-1:0] red_sample;

  modport source (output valid, output ir_sample, output red_sample, input ready);
  modport sink (input valid, input ir_sample, input red_sample, output ready);
endinterface

interface swe_out_if import swe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SPO2_W-1:0] spo2_percent;
  logic              window_ready;
  logic [OUT_W-1:0]  ir_mean;
  logic [OUT_W-1:0]  red_mean;
  logic [OUT_W-1:0]  ir_swing;
  logic [OUT_W-1:0]  red_swing;

  modport source (output valid, output spo2_percent, output window_ready, output ir_mean,
                  output red_mean, output ir_swing, output red_swing, input ready);
  modport sink (input valid, input spo2_percent, input window_ready, input ir_mean,
                input red_mean, input ir_swing, input red_swing, output ready);
endinterface

>>> src/swe_dp.sv
// Datapath: sample windows, scan, shared multiplier, divider, polynomial
module swe_dp import swe_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  input  logic [IN_W-1:0] ir_i,
  input  logic [IN_W-1:0] red_i,
  output status_t         status_o,
  output res_t            res_o
);

  logic [SAMPLE_BITS-1:0] ir_mem [WINDOW];
  logic [SAMPLE_BITS-1:0] red_mem [WINDOW];

  logic [AW-1:0]          wpos_q;
  logic [FILL_W-1:0]      fill_q;

  logic [SAMPLE_BITS-1:0] rd_ir_q, rd_red_q;
  logic [SAMPLE_BITS-1:0] ir_min_q, ir_max_q, red_min_q, red_max_q;
  logic [SUM_W-1:0]       ir_sum_q, red_sum_q;
  logic [SAMPLE_BITS-1:0] ir_sw_q, red_sw_q;
  logic [NUM_W-1:0]       num_q, den_q;
  logic [DSH_W-1:0]       rem_q, dsh_q;
  logic [QW-1:0]          quo_q;
  logic                   sat_q;
  logic [T_W-1:0]         t_q;
  logic [V_W-1:0]         lo_q, hi_q, bpr_q, v_q;
  logic                   neg_q;
  res_t                   res_q;

  logic [MUL_W-1:0]       mul_a, mul_b;
  logic [PROD_W-1:0]      prod;
  logic [QW-1:0]          r_val;
  logic                   rem_ge;
  logic [V_W-1:0]         pos, neg;
  logic [V_W-1:0]         v_round;
  logic                   calc_ok;
  logic [SPO2_W-1:0]      spo2_val;

  assign r_val  = sat_q ? '1 : quo_q;
  assign rem_ge = rem_q >= dsh_q;

  // one shared multiplier; operands picked by the current command
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_MUL_NUM: begin mul_a = MUL_W'(ir_sw_q);  mul_b = MUL_W'(red_sum_q); end
      OP_MUL_DEN: begin mul_a = MUL_W'(ir_sum_q); mul_b = MUL_W'(red_sw_q);  end
      OP_MUL_T:   begin mul_a = MUL_W'(COEF_A);   mul_b = MUL_W'(r_val);     end
      OP_MUL_LO:  begin mul_a = MUL_W'(t_q[HALF_T-1:0]); mul_b = MUL_W'(r_val); end
      OP_MUL_HI:  begin mul_a = MUL_W'(t_q[T_W-1:HALF_T]); mul_b = MUL_W'(r_val); end
      OP_MUL_B:   begin mul_a = MUL_W'(COEF_B);   mul_b = MUL_W'(r_val);     end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;

  assign neg = (hi_q << HALF_T) + lo_q;
  assign pos = (bpr_q << 16) + (V_W'(COEF_C) << 32);
  assign v_round = v_q + (V_W'(1) << 47);

  assign calc_ok = (ir_sum_q >= SUM_W'(WINDOW)) && (red_sum_q >= SUM_W'(WINDOW)) &&
                   (red_sw_q >= SAMPLE_BITS'(2));

  always_comb begin
    priority if (neg_q || !calc_ok) begin
      spo2_val = '0;
    end else if (v_q >= (V_W'(100) << 48)) begin
      spo2_val = SPO2_W'(100);
    end else begin
      spo2_val = SPO2_W'(v_round >> 48);
    end
  end

  assign status_o.fill_next = fill_q >= FILL_W'(WINDOW - 1);
  assign res_o = res_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.op == OP_WRITE) begin
      wpos_q <= (wpos_q == AW'(WINDOW - 1)) ? '0 : wpos_q + AW'(1);
      if (fill_q != FILL_W'(WINDOW)) fill_q <= fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WRITE) begin
      ir_mem[wpos_q]  <= SAMPLE_BITS'(ir_i);
      red_mem[wpos_q] <= SAMPLE_BITS'(red_i);
    end
    if (cmd_i.op == OP_SCAN && cmd_i.rd) begin
      rd_ir_q  <= ir_mem[cmd_i.addr];
      rd_red_q <= red_mem[cmd_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_WRITE: begin
        ir_min_q  <= '1;
        red_min_q <= '1;
        ir_max_q  <= '0;
        red_max_q <= '0;
        ir_sum_q  <= '0;
        red_sum_q <= '0;
      end
      OP_SCAN: begin
        if (cmd_i.acc) begin
          if (rd_ir_q < ir_min_q)   ir_min_q  <= rd_ir_q;
          if (rd_ir_q > ir_max_q)   ir_max_q  <= rd_ir_q;
          if (rd_red_q < red_min_q) red_min_q <= rd_red_q;
          if (rd_red_q > red_max_q) red_max_q <= rd_red_q;
          ir_sum_q  <= ir_sum_q + SUM_W'(rd_ir_q);
          red_sum_q <= red_sum_q + SUM_W'(rd_red_q);
        end
      end
      OP_SWING: begin
        ir_sw_q  <= ir_max_q - ir_min_q;
        red_sw_q <= red_max_q - red_min_q;
      end
      OP_MUL_NUM: num_q <= NUM_W'(prod);
      OP_MUL_DEN: den_q <= NUM_W'(prod);
      OP_DIV_INIT: begin
        rem_q <= DSH_W'({num_q, 16'b0});
        dsh_q <= DSH_W'(den_q) << (QW - 1);
        quo_q <= '0;
        sat_q <= (NUM_W + 4)'(num_q) >= ((NUM_W + 4)'(den_q) << 4);
      end
      OP_DIV_STEP: begin
        if (rem_ge) rem_q <= rem_q - dsh_q;
        dsh_q <= dsh_q >> 1;
        quo_q <= {quo_q[QW-2:0], rem_ge};
      end
      OP_MUL_T:  t_q   <= T_W'(prod);
      OP_MUL_LO: lo_q  <= V_W'(prod);
      OP_MUL_HI: hi_q  <= V_W'(prod);
      OP_MUL_B:  bpr_q <= V_W'(prod);
      OP_POLY: begin
        neg_q <= neg >= pos;
        v_q   <= pos - neg;
      end
      OP_FIN: begin
        if (fill_q == FILL_W'(WINDOW)) begin
          res_q.spo2_percent <= spo2_val;
          res_q.window_ready <= 1'b1;
          res_q.ir_mean      <= OUT_W'(ir_sum_q >> AW);
          res_q.red_mean     <= OUT_W'(red_sum_q >> AW);
          res_q.ir_swing     <= OUT_W'(ir_sw_q);
          res_q.red_swing    <= OUT_W'(red_sw_q);
        end else begin
          res_q <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> src/swe_ctrl.sv
// Controller: sequences write, scan, ratio division and polynomial per beat once the window is full
`include "spo2_window_estimator_assert.svh"

module swe_ctrl import swe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SWING, S_MUL_NUM, S_MUL_DEN, S_DIV_INIT, S_DIV,
    S_MUL_T, S_MUL_LO, S_MUL_HI, S_MUL_B, S_POLY, S_FIN
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             in_acc, out_acc, fin_go;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_q && out_ready_i;
  assign fin_go      = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '{op: OP_NONE, rd: 1'b0, acc: 1'b0, addr: '0};
    if (out_acc) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.op = OP_WRITE;
          cnt_d    = '0;
          state_d  = status_i.fill_next ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        cmd_o.op   = OP_SCAN;
        cmd_o.rd   = cnt_q < CNT_W'(WINDOW);
        cmd_o.acc  = cnt_q != '0;
        cmd_o.addr = cnt_q[AW-1:0];
        cnt_d      = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(WINDOW)) state_d = S_SWING;
      end
      S_SWING:    begin cmd_o.op = OP_SWING;   state_d = S_MUL_NUM; end
      S_MUL_NUM:  begin cmd_o.op = OP_MUL_NUM; state_d = S_MUL_DEN; end
      S_MUL_DEN:  begin cmd_o.op = OP_MUL_DEN; state_d = S_DIV_INIT; end
      S_DIV_INIT: begin
        cmd_o.op = OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QW - 1)) state_d = S_MUL_T;
      end
      S_MUL_T:  begin cmd_o.op = OP_MUL_T;  state_d = S_MUL_LO; end
      S_MUL_LO: begin cmd_o.op = OP_MUL_LO; state_d = S_MUL_HI; end
      S_MUL_HI: begin cmd_o.op = OP_MUL_HI; state_d = S_MUL_B;  end
      S_MUL_B:  begin cmd_o.op = OP_MUL_B;  state_d = S_POLY;   end
      S_POLY:   begin cmd_o.op = OP_POLY;   state_d = S_FIN;    end
      S_FIN: begin
        // wait here while the previous result is still held
        if (fin_go) begin
          cmd_o.op    = OP_FIN;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `SWE_ASSERT(a_one_beat_in_flight, in_acc |=> !in_ready_o, "second beat taken while busy")
  `SWE_ASSERT(a_valid_from_fin, $rose(out_valid_q) |-> $past(state_q == S_FIN),
              "result raised outside finish")
  `SWE_ASSERT(a_div_count, (state_q == S_DIV) |-> (cnt_q < CNT_W'(QW)),
              "divider step count overrun")
  `SWE_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == S_IDLE) || rst_ni,
                     "controller not idle in reset")

endmodule

>>> src/spo2_window_estimator.sv
// Per beat: a write, then the output step until the window fills; once it is full, a scan
// of the window (one read address per cycle), swing, both multiplies, divider setup, 20
// divider steps (one quotient bit each), the polynomial multiplies and sum, then output.
// Throughput: one beat at a time; the next beat is taken once the result is registered.
// Reset (rst_ni low, asynchronous) empties the window and drops out valid; window
// contents are not cleared, they are rewritten before being read.
module spo2_window_estimator import swe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  swe_in_if.sink    in_i,
  swe_out_if.source out_o
);

  cmd_t    cmd;
  status_t status;
  res_t    res;

  swe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  swe_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .ir_i     (in_i.ir_sample),
    .red_i    (in_i.red_sample),
    .status_o (status),
    .res_o    (res)
  );

  assign out_o.spo2_percent = res.spo2_percent;
  assign out_o.window_ready = res.window_ready;
  assign out_o.ir_mean      = res.ir_mean;
  assign out_o.red_mean     = res.red_mean;
  assign out_o.ir_swing     = res.ir_swing;
  assign out_o.red_swing    = res.red_swing;

endmodule

>>> bench/tb_if.sv
// Bench package with the sample pair beat type
`timescale 1ns / 100ps
package tb_spo2_pkg;
  import swe_pkg::*;

  typedef struct packed {
    logic [IN_W-1:0] ir;
    logic [IN_W-1:0] red;
  } pair_t;
endpackage

>>> bench/tb_top.sv
// Self-checking bench for the spo2 window estimator: sample pairs in, window results checked
`timescale 1ns / 100ps
module tb_top;
  import swe_pkg::*;
  import tb_spo2_pkg::*;

  localparam int LATENCY = WINDOW + 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  swe_in_if  in_ch ();
  swe_out_if out_ch ();

  spo2_window_estimator u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  pair_t pending_pairs[$];
  res_t  expected_results[$];

  // predictor state
  logic [SAMPLE_BITS-1:0] ir_win [WINDOW];
  logic [SAMPLE_BITS-1:0] red_win[WINDOW];
  int unsigned wr_pos = 0;
  int unsigned fill   = 0;

  int errors = 0;
  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  int valid_spo2 = 0;
  bit calm = 1'b0;   // no idling stretch
  bit hold_off = 1'b0;

  function automatic logic [19:0] ratio_q16(longint unsigned num, longint unsigned den);
    longint unsigned q, r;
    if (num >= 16 * den) return 20'hFFFFF;
    q = num / den;
    r = num % den;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q[19:0];
  endfunction

  function automatic logic [SPO2_W-1:0] spo2_of_ratio(logic [19:0] r);
    longint unsigned rr, neg, pos, v;
    rr  = longint'(r) * longint'(r);
    neg = 64'd2953052 * rr;
    pos = ((64'd1989280 * r) << 16) + (64'd6215762 << 32);
    if (neg >= pos) return '0;
    v = pos - neg;
    if (v >= (64'd100 << 48)) return SPO2_W'(100);
    return SPO2_W'((v + (64'd1 << 47)) >> 48);
  endfunction

  function automatic res_t estimate_window(pair_t p);
    res_t res;
    logic [SAMPLE_BITS-1:0] imin, imax, rmin, rmax;
    longint unsigned isum, rsum;
    logic [SAMPLE_BITS-1:0] isw, rsw;
    ir_win[wr_pos]  = p.ir[SAMPLE_BITS-1:0];
    red_win[wr_pos] = p.red[SAMPLE_BITS-1:0];
    wr_pos = (wr_pos + 1) % WINDOW;
    if (fill < WINDOW) fill++;
    res = '0;
    if (fill < WINDOW) return res;
    imin = '1; rmin = '1; imax = '0; rmax = '0; isum = 0; rsum = 0;
    for (int i = 0; i < WINDOW; i++) begin
      if (ir_win[i] < imin) imin = ir_win[i];
      if (ir_win[i] > imax) imax = ir_win[i];
      if (red_win[i] < rmin) rmin = red_win[i];
      if (red_win[i] > rmax) rmax = red_win[i];
      isum += ir_win[i];
      rsum += red_win[i];
    end
    isw = imax - imin;
    rsw = rmax - rmin;
    if (isum >= WINDOW && rsum >= WINDOW && rsw >= 2)
      res.spo2_percent = spo2_of_ratio(ratio_q16(isw * rsum, isum * rsw));
    res.window_ready = 1'b1;
    res.ir_mean   = OUT_W'(isum / WINDOW);
    res.red_mean  = OUT_W'(rsum / WINDOW);
    res.ir_swing  = OUT_W'(isw);
    res.red_swing = OUT_W'(rsw);
    return res;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid      <= 1'b0;
      in_ch.ir_sample  <= '0;
      in_ch.red_sample <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(estimate_window({in_ch.ir_sample, in_ch.red_sample}));
        beats_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_pairs.size() > 0 && !hold_off && (calm || $urandom_range(99) >= 13)) begin
          pair_t p;
          p = pending_pairs.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.ir_sample  <= p.ir;
          in_ch.red_sample <= p.red;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        res_t got, want;
        got = {out_ch.spo2_percent, out_ch.window_ready, out_ch.ir_mean, out_ch.red_mean,
               out_ch.ir_swing, out_ch.red_swing};
        beats_out++;
        if (expected_results.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result beat %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got.spo2_percent != 0) valid_spo2++;
          if (got !== want) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch beat %0d: exp %p got %p", beats_out, want, got);
          end
        end
      end
      out_ch.ready <= calm || $urandom_range(99) >= 13;
    end
  end

  function automatic pair_t rand_pair(int unsigned base_ir, int unsigned base_red,
                                      int unsigned amp);
    pair_t p;
    p.ir  = IN_W'(base_ir + $urandom_range(amp));
    p.red = IN_W'(base_red + $urandom_range(amp));
    return p;
  endfunction

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int unsigned bi, br, amp;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, zero mean, flat red, then a physiological window
    for (int i = 0; i < WINDOW; i++)
      pending_pairs.push_back(i % 2 ? pair_t'{IN_W'('1), IN_W'('1)} : pair_t'{'0, '0});
    for (int i = 0; i < 4; i++) pending_pairs.push_back('{'0, '0});
    for (int i = 0; i < 6; i++) pending_pairs.push_back('{IN_W'(100000 + i * 50), IN_W'(90000)});
    for (int i = 0; i < 6; i++) pending_pairs.push_back(rand_pair(100000, 80000, 4000));
    // red swing huge, ir tiny: polynomial goes negative or saturates
    for (int i = 0; i < 4; i++) pending_pairs.push_back('{IN_W'(200000), IN_W'(i * 60000)});
    wait_drained();

    // hold the sender until everything is back
    hold_off = 1'b1;
    repeat (LATENCY) @(posedge clk_i);
    hold_off = 1'b0;

    for (int blk = 0; blk < 23; blk++) begin
      calm = (blk == 10);
      bi = $urandom_range(262143 - 8192);
      br = $urandom_range(262143 - 8192);
      amp = (1 << $urandom_range(13)) - 1;
      for (int i = 0; i < 20; i++) begin
        if ($urandom_range(9) == 0) pending_pairs.push_back({IN_W'($urandom), IN_W'($urandom)});
        else if ($urandom_range(29) == 0)
          pending_pairs.push_back('{IN_W'($urandom_range(2)), IN_W'($urandom_range(2))});
        else pending_pairs.push_back(rand_pair(bi, br, amp));
      end
      wait_drained();
    end
    calm = 1'b0;
    repeat (LATENCY) @(posedge clk_i);

    $display("covered %0d sample pairs, %0d results, %0d with a nonzero saturation",
             beats_in, beats_out, valid_spo2);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end
endmodule
